@@ rtl/core/cls_pkg.sv @@
// Package for the command line splitter: sizes, character codes, result kinds,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package cls_pkg;

	// Backslash run capacity and argument count limit
	localparam int BS_MAX  = 32;
	localparam int ARG_MAX = 255;
	localparam int ARG_CAP = (ARG_MAX < 255) ? ARG_MAX : 255;

	// Widths of the input byte, the backslash counter and the argument count
	localparam int CH_W   = 8;
	localparam int PEND_W = 6;
	localparam int ARGS_W = 8;

	localparam logic [PEND_W-1:0] BS_MAX_V  = PEND_W'(BS_MAX);
	localparam logic [ARGS_W-1:0] ARG_CAP_V = ARGS_W'(ARG_CAP);

	// Character codes
	localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CH_W-1:0] CH_QUOTE = 8'h22;
	localparam logic [CH_W-1:0] CH_BSL   = 8'h5C;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_CHAR = 2'd0,
		KIND_END  = 2'd1,
		KIND_DONE = 2'd2
	} kind_t;

	// Controller states
	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} cls_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic emit;
	} cls_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic load_work;
		logic final_step;
		logic out_valid;
	} cls_status_t;

endpackage

@@ rtl/core/cls_in_if.sv @@
// Input channel of the command line splitter: one command-line byte per item.
// Depends on cls_pkg.
interface cls_in_if;
	import cls_pkg::*;

	logic            valid;
	logic            ready;
	logic [CH_W-1:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink   (input valid, input ch, output ready);

endinterface

@@ rtl/core/cls_out_if.sv @@
// Result channel of the command line splitter: argument bytes, end marks, line done.
// Depends on cls_pkg.
interface cls_out_if;
	import cls_pkg::*;

	logic              valid;
	logic              ready;
	logic [CH_W-1:0]   out_char;
	logic [1:0]        kind;
	logic [ARGS_W-1:0] arg_count;
	logic              overflow;
	logic              last;

	modport source (output valid, output out_char, output kind, output arg_count,
		output overflow, output last, input ready);
	modport sink   (input valid, input out_char, input kind, input arg_count,
		input overflow, input last, output ready);

endinterface

@@ rtl/core/cls_ctrl.sv @@
// Controller of the command line splitter: decides when an item is taken and
// when the datapath emits a result. Depends on cls_pkg.
module cls_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 out_ready,
	input  cls_pkg::cls_status_t status,
	output cls_pkg::cls_cmd_t    cmd
);
	import cls_pkg::*;

	cls_state_t state_q;
	cls_state_t state_nxt;
	logic       slot_free;

	assign slot_free = !status.out_valid || out_ready;

	// Issue commands: emit when the output register frees, take the next item
	// when idle or while the last result of the current item leaves
	always_comb begin
		cmd.emit   = (state_q == ST_EMIT) && slot_free;
		in_ready   = (state_q == ST_IDLE) || (cmd.emit && status.final_step);
		cmd.accept = in_valid && in_ready;
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.accept && status.load_work) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (cmd.emit && status.final_step) begin
					state_nxt = (cmd.accept && status.load_work) ? ST_EMIT : ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

@@ rtl/core/cls_dp.sv @@
// Datapath of the command line splitter: parse state, per-item emission plan
// and the output register. Depends on cls_pkg.
module cls_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [cls_pkg::CH_W-1:0]  ch,
	input  cls_pkg::cls_cmd_t         cmd,
	output cls_pkg::cls_status_t      status,
	input  logic                      out_ready,
	output logic                      out_valid,
	output logic [cls_pkg::CH_W-1:0]  out_char,
	output logic [1:0]                kind,
	output logic [cls_pkg::ARGS_W-1:0] arg_count,
	output logic                      overflow,
	output logic                      last
);
	import cls_pkg::*;

	// Parse state
	logic              quoted_q;
	logic              inside_q;
	logic [PEND_W-1:0] pend_q;
	logic [ARGS_W-1:0] args_q;
	logic              ovf_q;

	// Emission plan of the current item
	logic [PEND_W-1:0] cnt_q;
	logic              char_f_q;
	logic              end_f_q;
	logic              done_f_q;
	logic [CH_W-1:0]   ch_q;

	// Output register
	logic              out_valid_q;
	logic [CH_W-1:0]   out_char_q;
	logic [1:0]        kind_q;
	logic [ARGS_W-1:0] arg_count_q;
	logic              overflow_q;
	logic              last_q;

	// Plan for the incoming byte
	logic [PEND_W-1:0] nxt_cnt;
	logic              nxt_char;
	logic              nxt_end;
	logic              nxt_done;
	logic              nxt_quoted;
	logic              nxt_inside;
	logic [PEND_W-1:0] nxt_pend;
	logic              set_ovf;

	logic [ARGS_W-1:0] args_inc;
	logic [1:0]        flag_cnt;
	logic              has_work;

	// Decode the incoming byte against the current parse state
	always_comb begin
		nxt_cnt    = '0;
		nxt_char   = 1'b0;
		nxt_end    = 1'b0;
		nxt_done   = 1'b0;
		nxt_quoted = quoted_q;
		nxt_inside = inside_q;
		nxt_pend   = pend_q;
		set_ovf    = 1'b0;
		priority if (ch == CH_NUL) begin
			if (inside_q) begin
				nxt_cnt = pend_q;
				nxt_end = 1'b1;
			end
			nxt_done   = 1'b1;
			nxt_quoted = 1'b0;
			nxt_inside = 1'b0;
			nxt_pend   = '0;
		end else if (ch == CH_SPACE || ch == CH_TAB) begin
			if (inside_q) begin
				nxt_cnt  = pend_q;
				nxt_pend = '0;
				if (quoted_q) begin
					nxt_char = 1'b1;
				end else begin
					nxt_end    = 1'b1;
					nxt_inside = 1'b0;
					nxt_quoted = 1'b0;
				end
			end
		end else if (ch == CH_BSL) begin
			nxt_inside = 1'b1;
			if (pend_q < BS_MAX_V) begin
				nxt_pend = pend_q + 1'b1;
			end else begin
				set_ovf = 1'b1;
			end
		end else if (ch == CH_QUOTE) begin
			nxt_inside = 1'b1;
			nxt_cnt    = pend_q >> 1;
			nxt_char   = pend_q[0];
			nxt_quoted = pend_q[0] ? quoted_q : !quoted_q;
			nxt_pend   = '0;
		end else begin
			nxt_inside = 1'b1;
			nxt_cnt    = pend_q;
			nxt_char   = 1'b1;
			nxt_pend   = '0;
		end
	end

	// Status toward the controller
	always_comb begin
		args_inc = (args_q < ARG_CAP_V) ? args_q + 1'b1 : args_q;
		flag_cnt = {1'b0, char_f_q} + {1'b0, end_f_q} + {1'b0, done_f_q};
		has_work = (cnt_q != '0) || (flag_cnt != 2'd0);
		status.load_work  = (nxt_cnt != '0) || nxt_char || nxt_end || nxt_done;
		status.final_step = ((cnt_q == PEND_W'(1)) && (flag_cnt == 2'd0))
			|| ((cnt_q == '0) && (flag_cnt == 2'd1));
		status.out_valid  = out_valid_q;
	end

	// Control state: parse state, plan and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quoted_q    <= 1'b0;
			inside_q    <= 1'b0;
			pend_q      <= '0;
			args_q      <= '0;
			ovf_q       <= 1'b0;
			cnt_q       <= '0;
			char_f_q    <= 1'b0;
			end_f_q     <= 1'b0;
			done_f_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Retire one step of the plan
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
				end else if (char_f_q) begin
					char_f_q <= 1'b0;
				end else if (end_f_q) begin
					end_f_q <= 1'b0;
					args_q  <= args_inc;
				end else begin
					done_f_q <= 1'b0;
					args_q   <= '0;
					ovf_q    <= 1'b0;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			// Load the plan of a new item and advance the parse state
			if (cmd.accept) begin
				cnt_q    <= nxt_cnt;
				char_f_q <= nxt_char;
				end_f_q  <= nxt_end;
				done_f_q <= nxt_done;
				quoted_q <= nxt_quoted;
				inside_q <= nxt_inside;
				pend_q   <= nxt_pend;
				if (set_ovf) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	// Payload: input byte and output register
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ch_q <= ch;
		end
		if (cmd.emit) begin
			overflow_q <= ovf_q;
			last_q     <= status.final_step;
			if (cnt_q != '0) begin
				out_char_q  <= CH_BSL;
				kind_q      <= KIND_CHAR;
				arg_count_q <= args_q;
			end else if (char_f_q) begin
				out_char_q  <= ch_q;
				kind_q      <= KIND_CHAR;
				arg_count_q <= args_q;
			end else if (end_f_q) begin
				out_char_q  <= '0;
				kind_q      <= KIND_END;
				arg_count_q <= args_inc;
			end else begin
				out_char_q  <= '0;
				kind_q      <= KIND_DONE;
				arg_count_q <= args_q;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign kind      = kind_q;
	assign arg_count = arg_count_q;
	assign overflow  = overflow_q;
	assign last      = last_q;

	// Emit only while the plan holds work
	a_emit_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> has_work)
		else $error("emit with an empty plan");

	// A new item is loaded only once the plan is used up
	a_accept_plan_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> (!has_work || (cmd.emit && status.final_step)))
		else $error("item taken while results remain");

	// Backslash counter never passes its capacity
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= BS_MAX_V)
		else $error("backslash counter beyond capacity");

	// Terminator clears quoting and the pending run
	a_term_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && ch == CH_NUL) |=> (!quoted_q && !inside_q && pend_q == '0))
		else $error("terminator left parse state behind");

	// Argument count stays within its cap
	a_args_cap: assert property (@(posedge clk) disable iff (!arst_n)
		args_q <= ARG_CAP_V)
		else $error("argument count beyond cap");

endmodule

@@ rtl/core/command_line_splitter.sv @@
// Command line splitter: splits a byte stream of command lines into arguments.
// Top level; depends on cls_pkg, cls_in_if, cls_out_if, cls_ctrl and cls_dp.
//
// Usage:
//   cmd carries one command-line byte per item (ch); byte 0 ends the line.
//   res carries results: an argument byte (kind 0), an end-of-argument mark
//   (kind 1) or a line-finished mark (kind 2), each with the running argument
//   count and the backslash overflow flag of the line; last marks the final
//   result caused by one input byte. A byte may cause no result at all
//   (a backslash, or a separator between arguments).
// Sequencing: the results of a taken byte are planned in a register and then
//   move into the single output register, one result per cycle while res is
//   taken. A byte that ends a backslash run causes up to the run length plus
//   two results. Plain argument bytes stream at one item per cycle while res
//   is taken; the next byte is taken in the cycle its predecessor's last
//   result moves into the output register.
// Reset: arst_n clears the parse state, the argument count and the output
//   valid; the block is ready for a new line at once.
// Stall: when res is not taken, the output register holds its result and
//   the block stops taking bytes until the remaining results can move.
module command_line_splitter (
	input  logic      clk,
	input  logic      arst_n,
	cls_in_if.sink    cmd,
	cls_out_if.source res
);
	import cls_pkg::*;

	cls_cmd_t    ctrl_cmd;
	cls_status_t dp_status;

	// Sequence items and results
	cls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.out_ready (res.ready),
		.status    (dp_status),
		.cmd       (ctrl_cmd)
	);

	// Parse bytes and hold results
	cls_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ch        (cmd.ch),
		.cmd       (ctrl_cmd),
		.status    (dp_status),
		.out_ready (res.ready),
		.out_valid (res.valid),
		.out_char  (res.out_char),
		.kind      (res.kind),
		.arg_count (res.arg_count),
		.overflow  (res.overflow),
		.last      (res.last)
	);

endmodule

@@ tb/command_line_splitter_tb.sv @@
// Testbench for command_line_splitter: drives command-line bytes, predicts argument
// bytes, end marks and line-done results, and checks every result in order.
// Depends on cls_pkg, cls_in_if, cls_out_if and the command_line_splitter RTL.
module command_line_splitter_tb;
	import cls_pkg::*;

	// One result of the splitter as the predictor expects it
	typedef struct {
		logic [CH_W-1:0]   ch;
		kind_t             kind;
		logic [ARGS_W-1:0] count;
		logic              ovf;
		logic              fin;
	} split_result_t;

	// Argument splitting predictor and queue of expected results
	class splitter_scoreboard;
		split_result_t     expected_q[$];
		logic              quoted;
		logic              in_arg;
		logic [PEND_W-1:0] pend;
		logic [ARGS_W-1:0] args;
		logic              ovf;
		int                errors;

		function new();
			clear_line();
			errors = 0;
		endfunction

		function void clear_line();
			quoted = 1'b0;
			in_arg = 1'b0;
			pend   = '0;
			args   = '0;
			ovf    = 1'b0;
		endfunction

		function void push(logic [CH_W-1:0] c, kind_t k);
			split_result_t r;
			r.ch    = (k == KIND_CHAR) ? c : '0;
			r.kind  = k;
			r.count = args;
			r.ovf   = ovf;
			r.fin   = 1'b0;
			expected_q.push_back(r);
		endfunction

		function void emit_backslashes(int n);
			for (int i = 0; i < n; i++)
				push(CH_BSL, KIND_CHAR);
		endfunction

		// Flush the pending run, count the argument and mark its end
		function void close_argument();
			emit_backslashes(int'(pend));
			pend = '0;
			if (args < ARG_CAP_V)
				args++;
			push('0, KIND_END);
			in_arg = 1'b0;
			quoted = 1'b0;
		endfunction

		// Note an accepted byte and queue the results it causes
		function void note_byte(logic [CH_W-1:0] b);
			int first;
			first = expected_q.size();
			if (b == CH_NUL) begin
				if (in_arg)
					close_argument();
				push('0, KIND_DONE);
				clear_line();
			end else if (b == CH_SPACE || b == CH_TAB) begin
				if (in_arg) begin
					if (quoted) begin
						emit_backslashes(int'(pend));
						pend = '0;
						push(b, KIND_CHAR);
					end else begin
						close_argument();
					end
				end
			end else if (b == CH_BSL) begin
				in_arg = 1'b1;
				if (pend < BS_MAX_V)
					pend++;
				else
					ovf = 1'b1;
			end else if (b == CH_QUOTE) begin
				in_arg = 1'b1;
				emit_backslashes(int'(pend >> 1));
				if (pend[0])
					push(b, KIND_CHAR);
				else
					quoted = ~quoted;
				pend = '0;
			end else begin
				in_arg = 1'b1;
				emit_backslashes(int'(pend));
				pend = '0;
				push(b, KIND_CHAR);
			end
			if (expected_q.size() > first)
				expected_q[expected_q.size() - 1].fin = 1'b1;
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		// Compare a result with the oldest expectation
		task check_result(split_result_t got);
			split_result_t w;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0d char %02h",
					got.kind, got.ch));
			end else begin
				w = expected_q.pop_front();
				if (got.kind !== w.kind)
					report_mismatch($sformatf("kind %0d, want %0d", got.kind, w.kind));
				if (got.ch !== w.ch)
					report_mismatch($sformatf("out_char %02h, want %02h", got.ch, w.ch));
				if (got.count !== w.count)
					report_mismatch($sformatf("arg_count %0d, want %0d",
						got.count, w.count));
				if (got.ovf !== w.ovf)
					report_mismatch($sformatf("overflow %b, want %b", got.ovf, w.ovf));
				if (got.fin !== w.fin)
					report_mismatch($sformatf("last %b, want %b", got.fin, w.fin));
			end
		endtask

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	cls_in_if  cmd_ch();
	cls_out_if res_ch();

	command_line_splitter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	splitter_scoreboard sb = new();

	int   bytes_sent   = 0;
	int   results_seen = 0;
	logic noisy        = 1'b1;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Bound the run
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	// Offer one byte, with random idle cycles ahead of it, and wait until taken
	task automatic send_byte(logic [CH_W-1:0] b);
		while (noisy && $urandom_range(0, 99) < 19) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.ch    <= b;
		do
			@(posedge clk);
		while (cmd_ch.ready !== 1'b1);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	function automatic logic [CH_W-1:0] word_byte();
		if ($urandom_range(0, 3) != 0)
			return CH_W'($urandom_range(8'h61, 8'h7a));
		else
			return CH_W'($urandom_range(1, 255));
	endfunction

	function automatic logic [CH_W-1:0] pick_sep();
		if ($urandom_range(0, 1) != 0)
			return CH_SPACE;
		else
			return CH_TAB;
	endfunction

	// Send a backslash run and the byte that decides its meaning
	task automatic send_backslash_run(int n, logic [CH_W-1:0] follow);
		repeat (n) send_byte(CH_BSL);
		send_byte(follow);
	endtask

	// Send one line of random tokens, closed by the terminator
	task automatic send_random_line();
		int               tokens;
		int               n;
		logic [CH_W-1:0]  follow;
		tokens = $urandom_range(0, 8);
		for (int i = 0; i < tokens; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					n = $urandom_range(1, 6);
					repeat (n) send_byte(word_byte());
				end
				3: begin
					send_byte(CH_QUOTE);
					n = $urandom_range(0, 6);
					repeat (n) send_byte(($urandom_range(0, 3) == 0) ? pick_sep() : word_byte());
					if ($urandom_range(0, 3) != 0)
						send_byte(CH_QUOTE);
				end
				4: begin
					n = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 5);
					case ($urandom_range(0, 9))
						0, 1, 2, 3: follow = CH_QUOTE;
						4, 5:       follow = word_byte();
						6:          follow = CH_SPACE;
						7:          follow = CH_TAB;
						8:          follow = CH_BSL;
						default:    follow = CH_NUL;
					endcase
					send_backslash_run(n, follow);
				end
				5: begin
					n = $urandom_range(1, 3);
					repeat (n) send_byte(pick_sep());
				end
				6: send_byte(CH_W'($urandom_range(0, 255)));
				7: send_byte(CH_QUOTE);
				default: send_byte(CH_SPACE);
			endcase
		end
		send_byte(CH_NUL);
	endtask

	// Take results, with random stalls and one long hold-off
	initial begin
		int   hold_left;
		logic held_once;
		split_result_t got;
		hold_left    = 0;
		held_once    = 1'b0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
				got.ch    = res_ch.out_char;
				got.kind  = kind_t'(res_ch.kind);
				got.count = res_ch.arg_count;
				got.ovf   = res_ch.overflow;
				got.fin   = res_ch.last;
				sb.check_result(got);
				results_seen++;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (!held_once && results_seen >= 150) begin
				held_once = 1'b1;
				hold_left = 300;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= !(noisy && $urandom_range(0, 99) < 19);
			end
		end
	end

	// Reset, stimulus and end of run
	initial begin
		int random_start;
		arst_n       <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.ch    <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Separators outside an argument, extreme bytes, quoted separators
		send_byte(CH_SPACE);
		send_byte(CH_TAB);
		send_byte(8'h01);
		send_byte(8'hFF);
		send_byte(CH_SPACE);
		send_byte(CH_QUOTE);
		send_byte(8'h78);
		send_byte(CH_SPACE);
		send_byte(CH_TAB);
		send_byte(CH_QUOTE);
		// Even run before a quote toggles, odd run gives a literal quote
		send_backslash_run(2, CH_QUOTE);
		send_backslash_run(3, CH_QUOTE);
		send_backslash_run(1, 8'h7A);
		send_backslash_run(1, CH_SPACE);
		send_byte(CH_QUOTE);
		// Backslash runs flushed before an unquoted separator and the terminator
		send_backslash_run(2, CH_SPACE);
		send_backslash_run(1, CH_TAB);
		send_backslash_run(1, CH_NUL);
		// Unclosed quote cleared by the terminator, then an empty line
		send_byte(CH_QUOTE);
		send_byte(8'h71);
		send_byte(CH_NUL);
		send_byte(CH_NUL);

		// Overflow the backslash counter
		send_backslash_run(40, CH_QUOTE);
		send_byte(CH_NUL);

		// Random lines, with a quiet stretch in the middle
		random_start = bytes_sent;
		while (bytes_sent < random_start + 320) begin
			noisy = !(bytes_sent >= random_start + 150 && bytes_sent < random_start + 260);
			send_random_line();
		end
		noisy = 1'b1;

		cmd_ch.valid <= 1'b0;

		// Drain, then allow for stray results
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.pending() > 0)
			sb.report_mismatch($sformatf("%0d expected results never came", sb.pending()));
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/cls_pkg.sv
rtl/core/cls_in_if.sv
rtl/core/cls_out_if.sv
rtl/core/cls_ctrl.sv
rtl/core/cls_dp.sv
rtl/core/command_line_splitter.sv
tb/command_line_splitter_tb.sv
